[rtl/srtf_pkg.sv]
// Shared types and defaults for the SRTF job scheduler.
// Used by srtf_cell and srtf_job_scheduler_unit; no dependencies.
package srtf_pkg;

  localparam int JOB_SLOTS_DEF  = 16;
  localparam int BURST_BITS_DEF = 8;
  localparam int TIME_BITS_DEF  = 16;

  // one-cycle commands broadcast from the controller to every cell
  typedef struct packed {
    logic arrive;   // load a new job into the addressed cell
    logic restamp;  // give the addressed cell a fresh order stamp
    logic run;      // the addressed cell runs for one time unit
  } cmd_t;

  // serial-number compare: a is older than b
  function automatic logic older(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

[rtl/srtf_cell.sv]
// One job slot of the scheduler plus one stage of the selection chain.
// Depends on srtf_pkg (cmd_t, older).
module srtf_cell import srtf_pkg::*; #(
  parameter int INDEX      = 0,
  parameter int SLOT_W     = 4,
  parameter int BURST_BITS = BURST_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [SLOT_W-1:0]     cmd_slot,
  input  logic [BURST_BITS-1:0] wr_burst,
  input  logic [TIME_BITS-1:0]  wr_time,
  input  logic [31:0]           wr_seq,
  input  logic                  c_valid_in,
  input  logic [SLOT_W-1:0]     c_slot_in,
  input  logic [BURST_BITS-1:0] c_rem_in,
  input  logic [31:0]           c_order_in,
  input  logic [TIME_BITS-1:0]  c_arr_in,
  input  logic [BURST_BITS-1:0] c_burst_in,
  output logic                  c_valid_out,
  output logic [SLOT_W-1:0]     c_slot_out,
  output logic [BURST_BITS-1:0] c_rem_out,
  output logic [31:0]           c_order_out,
  output logic [TIME_BITS-1:0]  c_arr_out,
  output logic [BURST_BITS-1:0] c_burst_out,
  output logic                  busy
);

  logic [BURST_BITS-1:0] rem;
  logic [BURST_BITS-1:0] bst;
  logic [TIME_BITS-1:0]  arr;
  logic [31:0]           ord;
  logic                  hit;
  logic                  take;

  assign hit = (cmd_slot == SLOT_W'(INDEX));

  // this slot beats the candidate handed in from the left
  assign take = busy && (!c_valid_in || (rem < c_rem_in) ||
                         ((rem == c_rem_in) && older(ord, c_order_in)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (hit) begin
      if (cmd.arrive) begin
        busy <= 1'b1;
      end else if (cmd.run && rem == BURST_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && cmd.arrive) begin
      rem <= wr_burst;
      bst <= wr_burst;
      arr <= wr_time;
      ord <= wr_seq;
    end else if (hit && cmd.restamp) begin
      ord <= wr_seq;
    end else if (hit && cmd.run) begin
      rem <= rem - BURST_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid_out <= 1'b0;
    end else begin
      c_valid_out <= c_valid_in || busy;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      c_slot_out  <= SLOT_W'(INDEX);
      c_rem_out   <= rem;
      c_order_out <= ord;
      c_arr_out   <= arr;
      c_burst_out <= bst;
    end else begin
      c_slot_out  <= c_slot_in;
      c_rem_out   <= c_rem_in;
      c_order_out <= c_order_in;
      c_arr_out   <= c_arr_in;
      c_burst_out <= c_burst_in;
    end
  end

endmodule

[rtl/srtf_job_scheduler_unit.sv]
// Shortest-remaining-time-first scheduler: controller, cell row, result register.
// Depends on srtf_pkg and srtf_cell.
//
// Each job slot lives in a cell; the cells form a registered chain that passes the
// best candidate so far one cell per cycle; a tick steps through accept, restamp, the
// sweep through the chain and the result, and an arrival through accept and result.
// One transaction is handled at a time; a result waits in the output register while
// the downstream side stalls. Ties on remaining time go to the oldest order stamp;
// the job that ran last is restamped at the next tick.
module srtf_job_scheduler_unit import srtf_pkg::*; #(
  parameter int JOB_SLOTS  = JOB_SLOTS_DEF,
  parameter int BURST_BITS = BURST_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [3:0]  job_slot,
  input  logic [7:0]  burst_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        ran_valid,
  output logic [3:0]  ran_slot,
  output logic        finished,
  output logic [15:0] done_time,
  output logic [15:0] turnaround,
  output logic [15:0] waiting
);

  localparam int SLOT_W = $clog2(JOB_SLOTS);
  localparam int WIDE   = TIME_BITS + BURST_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ARR   = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]            state;
  logic [SLOT_W-1:0]     cnt;
  logic [3:0]            item_slot;
  logic [7:0]            item_burst;
  logic [TIME_BITS-1:0]  time_now;
  logic [31:0]           seq;
  logic                  last_valid;
  logic [SLOT_W-1:0]     last_slot;

  logic                  c_valid [JOB_SLOTS+1];
  logic [SLOT_W-1:0]     c_slot  [JOB_SLOTS+1];
  logic [BURST_BITS-1:0] c_rem   [JOB_SLOTS+1];
  logic [31:0]           c_order [JOB_SLOTS+1];
  logic [TIME_BITS-1:0]  c_arr   [JOB_SLOTS+1];
  logic [BURST_BITS-1:0] c_burst [JOB_SLOTS+1];
  logic [JOB_SLOTS-1:0]  busy_vec;

  cmd_t                  cmd;
  logic [SLOT_W-1:0]     cmd_slot;
  logic [SLOT_W+3:0]     slot_ext;
  logic [SLOT_W-1:0]     item_idx;
  logic                  slot_ok;
  logic [15:0]           burst_ext;
  logic [BURST_BITS-1:0] burst_w;
  logic                  arr_ok;
  logic                  out_free;
  logic                  res_load;
  logic                  tail_fin;
  logic [TIME_BITS-1:0]  turn_t;
  logic [WIDE-1:0]       wait_wide;
  logic [SLOT_W+3:0]     ran_ext;
  logic [TIME_BITS+15:0] done_ext;
  logic [TIME_BITS+15:0] turn_ext;
  logic [WIDE+15:0]      wait_ext;

  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign res_load  = out_free && (state == ST_ARR || state == ST_DONE);

  assign slot_ext  = {{SLOT_W{1'b0}}, item_slot};
  assign item_idx  = slot_ext[SLOT_W-1:0];
  assign slot_ok   = slot_ext < (SLOT_W+4)'(JOB_SLOTS);
  assign burst_ext = {8'd0, item_burst};
  assign burst_w   = burst_ext[BURST_BITS-1:0];
  assign arr_ok    = slot_ok && !busy_vec[item_idx] && (burst_w != '0);

  // chain tail holds the winner once the sweep has run through every cell
  assign tail_fin  = c_valid[JOB_SLOTS] && (c_rem[JOB_SLOTS] == BURST_BITS'(1));
  assign turn_t    = time_now - c_arr[JOB_SLOTS];
  assign wait_wide = {{BURST_BITS{1'b0}}, turn_t} - {{TIME_BITS{1'b0}}, c_burst[JOB_SLOTS]};
  assign ran_ext   = {4'd0, c_slot[JOB_SLOTS]};
  assign done_ext  = {16'd0, time_now};
  assign turn_ext  = {16'd0, turn_t};
  assign wait_ext  = {16'd0, {BURST_BITS{1'b0}}, wait_wide[TIME_BITS-1:0]};

  always_comb begin
    cmd      = '0;
    cmd_slot = c_slot[JOB_SLOTS];
    case (state)
      ST_ARR: begin
        cmd_slot   = item_idx;
        cmd.arrive = out_free && arr_ok;
      end
      ST_PREP: begin
        cmd_slot    = last_slot;
        cmd.restamp = last_valid;
      end
      ST_DONE: begin
        cmd.run = out_free && c_valid[JOB_SLOTS];
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign c_valid[0] = 1'b0;
  assign c_slot[0]  = '0;
  assign c_rem[0]   = '0;
  assign c_order[0] = '0;
  assign c_arr[0]   = '0;
  assign c_burst[0] = '0;

  for (genvar i = 0; i < JOB_SLOTS; i++) begin : g_cell
    srtf_cell #(
      .INDEX      (i),
      .SLOT_W     (SLOT_W),
      .BURST_BITS (BURST_BITS),
      .TIME_BITS  (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .cmd_slot    (cmd_slot),
      .wr_burst    (burst_w),
      .wr_time     (time_now),
      .wr_seq      (seq),
      .c_valid_in  (c_valid[i]),
      .c_slot_in   (c_slot[i]),
      .c_rem_in    (c_rem[i]),
      .c_order_in  (c_order[i]),
      .c_arr_in    (c_arr[i]),
      .c_burst_in  (c_burst[i]),
      .c_valid_out (c_valid[i+1]),
      .c_slot_out  (c_slot[i+1]),
      .c_rem_out   (c_rem[i+1]),
      .c_order_out (c_order[i+1]),
      .c_arr_out   (c_arr[i+1]),
      .c_burst_out (c_burst[i+1]),
      .busy        (busy_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_slot  <= job_slot;
      item_burst <= burst_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      time_now   <= '0;
      seq        <= '0;
      last_valid <= 1'b0;
      last_slot  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= func ? ST_PREP : ST_ARR;
          end
        end
        ST_ARR: begin
          if (out_free) begin
            if (arr_ok) begin
              seq <= seq + 32'd1;
            end
            state <= ST_IDLE;
          end
        end
        ST_PREP: begin
          if (last_valid) begin
            seq <= seq + 32'd1;
          end
          time_now <= time_now + TIME_BITS'(1);
          cnt      <= '0;
          state    <= ST_SWEEP;
        end
        ST_SWEEP: begin
          cnt <= cnt + SLOT_W'(1);
          if (cnt == SLOT_W'(JOB_SLOTS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            last_valid <= c_valid[JOB_SLOTS] && !tail_fin;
            last_slot  <= c_slot[JOB_SLOTS];
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_ARR && out_free) begin
      accepted   <= arr_ok;
      ran_valid  <= 1'b0;
      ran_slot   <= '0;
      finished   <= 1'b0;
      done_time  <= '0;
      turnaround <= '0;
      waiting    <= '0;
    end else if (state == ST_DONE && out_free) begin
      accepted  <= 1'b0;
      ran_valid <= c_valid[JOB_SLOTS];
      ran_slot  <= c_valid[JOB_SLOTS] ? ran_ext[3:0] : 4'd0;
      finished  <= tail_fin;
      if (tail_fin) begin
        done_time  <= done_ext[15:0];
        turnaround <= turn_ext[15:0];
        waiting    <= wait_ext[15:0];
      end else begin
        done_time  <= '0;
        turnaround <= '0;
        waiting    <= '0;
      end
    end
  end

  a_fin_has_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!finished || ran_valid))
    else $error("finished reported without a job having run");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && ran_valid))
    else $error("result marks both an arrival and a tick");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    ##1 ((seq == $past(seq)) || (seq == $past(seq) + 32'd1)))
    else $error("sequence counter moved by more than one");

  a_fin_clears_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free && tail_fin) |=> !last_valid)
    else $error("finished job still marked as last run");

  a_restamp_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP && last_valid) |-> busy_vec[last_slot])
    else $error("restamp aimed at a free slot");

endmodule
